>>> hdl/heater_cycle_controller_macros.svh
// Assertion helpers used by the checker file.
`ifndef HEATER_CYCLE_CONTROLLER_MACROS_SVH
`define HEATER_CYCLE_CONTROLLER_MACROS_SVH

// Clocked check, idle while reset is high.
`define HCC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("heater cycle controller check failed");

// Clocked check that also covers the reset cycles.
`define HCC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("heater cycle controller reset check failed");

`endif

>>> hdl/hcc_pkg.sv
package hcc_pkg;

   localparam int TEMP_W  = 10;
   localparam int TIME_W  = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TEMP   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_TEMP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_MS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_LOW   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_MID   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_HIGH  = 3'd5;

   // register reset values
   localparam logic [TEMP_W-1:0] MAX_TEMP_RST   = 10'd200;
   localparam logic [TEMP_W-1:0] RESET_TEMP_RST = 10'd50;
   localparam logic [TIME_W-1:0] HOLD_MS_RST    = 32'd60000;
   localparam logic [TEMP_W-1:0] BAND_LOW_RST   = 10'd150;
   localparam logic [TEMP_W-1:0] BAND_MID_RST   = 10'd230;
   localparam logic [TEMP_W-1:0] BAND_HIGH_RST  = 10'd300;

   // external mode codes
   localparam logic [1:0] MODE_CODE_STANDBY  = 2'd0;
   localparam logic [1:0] MODE_CODE_WARMING  = 2'd1;
   localparam logic [1:0] MODE_CODE_FINISHED = 2'd2;

   localparam logic [1:0] LED_OFF           = 2'd0;
   localparam logic [1:0] LED_SOLID         = 2'd1;
   localparam logic [1:0] LED_BLINK_STANDBY = 2'd2;
   localparam logic [1:0] LED_BLINK_WARMING = 2'd3;

   localparam logic [2:0] COL_WHITE  = 3'd0;
   localparam logic [2:0] COL_GREEN  = 3'd1;
   localparam logic [2:0] COL_BLUE   = 3'd2;
   localparam logic [2:0] COL_PURPLE = 3'd3;
   localparam logic [2:0] COL_YELLOW = 3'd4;
   localparam logic [2:0] COL_RED    = 3'd5;

   typedef enum logic [2:0] {
      MODE_STANDBY  = 3'b001,
      MODE_WARMING  = 3'b010,
      MODE_FINISHED = 3'b100
   } mode_type;

   typedef struct packed {
      logic [TEMP_W-1:0] max_temp;
      logic [TEMP_W-1:0] reset_temp;
      logic [TIME_W-1:0] hold_ms;
      logic [TEMP_W-1:0] band_low;
      logic [TEMP_W-1:0] band_mid;
      logic [TEMP_W-1:0] band_high;
   } cfg_type;

   typedef struct packed {
      mode_type          mode;
      logic              hold_armed;
      logic [TIME_W-1:0] hold_start;
      logic              press_latched;
   } state_type;

   typedef struct packed {
      logic [TEMP_W-1:0] temp_sample;
      logic              button_press;
      logic              button_level;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic       relay_on;
      logic [1:0] mode_now;
      logic [1:0] led_cmd;
      logic [2:0] led_colour;
   } rsp_type;

endpackage

>>> hdl/hcc_pass.sv
// One controller pass: button, LED, hold timer and cool-down in that order.
module hcc_pass
   import hcc_pkg::*;
(
   input  cfg_type   cfg,
   input  state_type state,
   input  req_type   item,
   output state_type state_next,
   output rsp_type   rsp
);

   mode_type          mode_btn;
   mode_type          mode_fin;
   logic              act;
   logic              latched_btn;
   logic [TIME_W-1:0] elapsed;
   logic [2:0]        band;

   always_comb begin
      if (item.temp_sample <= cfg.band_low) begin
         band = COL_BLUE;
      end else if (item.temp_sample <= cfg.band_mid) begin
         band = COL_PURPLE;
      end else if (item.temp_sample <= cfg.band_high) begin
         band = COL_YELLOW;
      end else begin
         band = COL_RED;
      end
   end

   assign elapsed = item.now_ms - state.hold_start;

   always_comb begin
      // button step
      act      = item.button_press && !state.press_latched;
      mode_btn = state.mode;
      if (act) begin
         if (state.mode == MODE_STANDBY) begin
            mode_btn = (item.temp_sample < cfg.max_temp) ? MODE_WARMING : MODE_FINISHED;
         end else begin
            mode_btn = MODE_STANDBY;
         end
      end
      latched_btn = (act || state.press_latched) && item.button_level;

      // LED from the mode after the button step
      if (item.button_level) begin
         if (!latched_btn) begin
            rsp.led_cmd    = LED_SOLID;
            rsp.led_colour = COL_WHITE;
         end else begin
            rsp.led_cmd    = LED_OFF;
            rsp.led_colour = COL_WHITE;
         end
      end else if (mode_btn == MODE_STANDBY) begin
         rsp.led_cmd    = LED_BLINK_STANDBY;
         rsp.led_colour = COL_GREEN;
      end else if (mode_btn == MODE_WARMING) begin
         rsp.led_cmd    = LED_BLINK_WARMING;
         rsp.led_colour = band;
      end else begin
         rsp.led_cmd    = LED_SOLID;
         rsp.led_colour = band;
      end

      // timer and cool-down act on the entry mode
      state_next.hold_armed    = state.hold_armed;
      state_next.hold_start    = state.hold_start;
      state_next.press_latched = latched_btn;
      mode_fin                 = mode_btn;
      if (state.mode == MODE_WARMING) begin
         if (item.temp_sample >= cfg.max_temp && !state.hold_armed) begin
            state_next.hold_armed = 1'b1;
            state_next.hold_start = item.now_ms;
         end else if (state.hold_armed && elapsed >= cfg.hold_ms) begin
            state_next.hold_armed = 1'b0;
            state_next.hold_start = '0;
            mode_fin              = MODE_FINISHED;
         end
      end else if (state.mode == MODE_FINISHED) begin
         if (item.temp_sample <= cfg.reset_temp) begin
            mode_fin = MODE_STANDBY;
         end
      end
      state_next.mode = mode_fin;

      rsp.relay_on = (state.mode == MODE_WARMING);
      unique case (mode_fin)
         MODE_STANDBY:  rsp.mode_now = MODE_CODE_STANDBY;
         MODE_WARMING:  rsp.mode_now = MODE_CODE_WARMING;
         MODE_FINISHED: rsp.mode_now = MODE_CODE_FINISHED;
         default:       rsp.mode_now = MODE_CODE_STANDBY;
      endcase
   end

endmodule

>>> hdl/heater_cycle_controller.sv
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+---------------------------------------------
// req      | in        | req_valid/req_stall | temp_sample, button_press, button_level, now_ms
// rsp      | out       | rsp_valid/rsp_stall | relay_on, mode_now, led_cmd, led_colour
// csr      | in        | csr_wr_en           | csr_index, csr_wdata
//
// One item per cycle while rsp_stall is low; items go through the input and result registers.
// The rate is set by the mode/timer state loop through hcc_pass and the state register.
// Synchronous active-high reset clears mode, timer, latch, valids and loads register defaults.
// A stalled result holds in the result register while the input register still takes an item;
// req_stall rises only when both registers hold items and rsp_stall is high.
module heater_cycle_controller
   import hcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [TEMP_W-1:0]     req_temp_sample,
   input  logic                  req_button_press,
   input  logic                  req_button_level,
   input  logic [TIME_W-1:0]     req_now_ms,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_relay_on,
   output logic [1:0]            rsp_mode_now,
   output logic [1:0]            rsp_led_cmd,
   output logic [2:0]            rsp_led_colour,

   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type   cfg_ff;
   state_type state_ff;
   state_type state_in;
   req_type   item_ff;
   logic      item_valid_ff;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      rsp_valid_ff;
   logic      advance;
   logic      take;

   // Configuration registers: written by the user only while the block is idle; not enforced.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_temp   <= MAX_TEMP_RST;
         cfg_ff.reset_temp <= RESET_TEMP_RST;
         cfg_ff.hold_ms    <= HOLD_MS_RST;
         cfg_ff.band_low   <= BAND_LOW_RST;
         cfg_ff.band_mid   <= BAND_MID_RST;
         cfg_ff.band_high  <= BAND_HIGH_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAX_TEMP:   cfg_ff.max_temp   <= csr_wdata[TEMP_W-1:0];
            CSR_RESET_TEMP: cfg_ff.reset_temp <= csr_wdata[TEMP_W-1:0];
            CSR_HOLD_MS:    cfg_ff.hold_ms    <= csr_wdata[TIME_W-1:0];
            CSR_BAND_LOW:   cfg_ff.band_low   <= csr_wdata[TEMP_W-1:0];
            CSR_BAND_MID:   cfg_ff.band_mid   <= csr_wdata[TEMP_W-1:0];
            CSR_BAND_HIGH:  cfg_ff.band_high  <= csr_wdata[TEMP_W-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // Move the held item into the result register when that register is free
   // or being drained this cycle; the controller state commits on the same edge.
   assign advance   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (take) begin
         item_valid_ff <= 1'b1;
      end else if (advance) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.temp_sample  <= req_temp_sample;
         item_ff.button_press <= req_button_press;
         item_ff.button_level <= req_button_level;
         item_ff.now_ms       <= req_now_ms;
      end
   end

   hcc_pass u_pass (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .item       (item_ff),
      .state_next (state_in),
      .rsp        (rsp_in)
   );

   // Controller state: advance once per item, in item order.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode          <= MODE_STANDBY;
         state_ff.hold_armed    <= 1'b0;
         state_ff.hold_start    <= '0;
         state_ff.press_latched <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register: hold while stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_relay_on   = rsp_ff.relay_on;
   assign rsp_mode_now   = rsp_ff.mode_now;
   assign rsp_led_cmd    = rsp_ff.led_cmd;
   assign rsp_led_colour = rsp_ff.led_colour;

endmodule

>>> hdl/hcc_checker.sv
`include "heater_cycle_controller_macros.svh"

module hcc_checker
   import hcc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_relay_on,
   input logic [1:0] rsp_mode_now,
   input logic [1:0] rsp_led_cmd,
   input logic [2:0] rsp_led_colour
);

   logic [7:0] rsp_fields;
   logic       codes_legal;

   assign rsp_fields  = {rsp_relay_on, rsp_mode_now, rsp_led_cmd, rsp_led_colour};
   assign codes_legal = (rsp_mode_now <= MODE_CODE_FINISHED) && (rsp_led_colour <= COL_RED);

   // hold a stalled result
   `HCC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)
   `HCC_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_fields))
   // reset drops any pending result
   `HCC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)
   // codes stay in their legal ranges
   `HCC_ASSERT(a_codes_legal, clock, reset, rsp_valid |-> codes_legal)

endmodule

bind heater_cycle_controller hcc_checker u_hcc_checker (.*);

>>> bench/heater_cycle_controller_tb.sv
module heater_cycle_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hcc_pkg::*;

   // Longest wait either side may draw for one item.
   localparam int MAX_WAIT = 17;
   // Cycle limit, kept well above the length of the worst correct run.
   localparam int CYCLE_LIMIT = 400000;
   // Settle a little longer at the end, after the last result is due.
   localparam int SETTLE_CYCLES = 8;
   // Random register settings visited, and passes run under each one.
   localparam int NUM_SETTINGS = 8;
   localparam int PASSES_PER_SETTING = 142;

   // Drive every input to a known value from time zero.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [TEMP_W-1:0]     req_temp_sample = '0;
   logic                  req_button_press = 1'b0;
   logic                  req_button_level = 1'b0;
   logic [TIME_W-1:0]     req_now_ms = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_relay_on;
   logic [1:0]            rsp_mode_now;
   logic [1:0]            rsp_led_cmd;
   logic [2:0]            rsp_led_colour;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Controller state as the bench predicts it, plus its own register copy.
   cfg_type           settings;
   logic [1:0]        ctl_mode;
   logic              timer_armed;
   logic [TIME_W-1:0] timer_start;
   logic              press_held;

   // Results predicted for accepted items, oldest first.
   rsp_type predicted_passes[$];

   // Pacing switches: when low, that side never idles.
   logic feed_idle = 1'b1;
   logic sink_idle = 1'b1;

   // Random walk state for the heating sequences.
   int                walk_temp;
   logic [TIME_W-1:0] walk_ms;
   int                btn_hold;

   int cycle_count = 0;
   int passes_sent = 0;
   int results_seen = 0;
   int mismatches = 0;
   int timer_finishes = 0;
   int settings_used = 0;

   heater_cycle_controller uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_temp_sample  (req_temp_sample),
      .req_button_press (req_button_press),
      .req_button_level (req_button_level),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_relay_on     (rsp_relay_on),
      .rsp_mode_now     (rsp_mode_now),
      .rsp_led_cmd      (rsp_led_cmd),
      .rsp_led_colour   (rsp_led_colour),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Map a temperature onto the colour bands; the first band that holds it wins.
   function automatic logic [2:0] colour_band(input logic [TEMP_W-1:0] t);
      if (t <= settings.band_low) return COL_BLUE;
      if (t <= settings.band_mid) return COL_PURPLE;
      if (t <= settings.band_high) return COL_YELLOW;
      return COL_RED;
   endfunction

   // Run one controller pass on the predicted state and return its result.
   function automatic rsp_type run_controller_pass(input req_type item);
      rsp_type           res;
      logic [1:0]        entry;
      logic [TIME_W-1:0] elapsed;
      entry = ctl_mode;

      // Act on a fresh press once, then hold the latch until release.
      if (item.button_press && !press_held) begin
         if (ctl_mode == MODE_CODE_STANDBY) begin
            ctl_mode = (item.temp_sample < settings.max_temp) ? MODE_CODE_WARMING
                                                               : MODE_CODE_FINISHED;
         end else begin
            ctl_mode = MODE_CODE_STANDBY;
         end
         press_held = 1'b1;
      end
      if (!item.button_level) press_held = 1'b0;

      // LED follows the mode left by the button step, not the final mode.
      if (item.button_level) begin
         // Held and latched turns the LED off with a zero colour field.
         res.led_cmd    = press_held ? LED_OFF : LED_SOLID;
         res.led_colour = COL_WHITE;
      end else begin
         case (ctl_mode)
            MODE_CODE_STANDBY: begin
               res.led_cmd    = LED_BLINK_STANDBY;
               res.led_colour = COL_GREEN;
            end
            MODE_CODE_WARMING: begin
               res.led_cmd    = LED_BLINK_WARMING;
               res.led_colour = colour_band(item.temp_sample);
            end
            default: begin
               res.led_cmd    = LED_SOLID;
               res.led_colour = colour_band(item.temp_sample);
            end
         endcase
      end

      // Timer check keys off the entry mode, so it still runs after a button exit.
      if (entry == MODE_CODE_WARMING) begin
         elapsed = item.now_ms - timer_start;
         if (item.temp_sample >= settings.max_temp && !timer_armed) begin
            timer_armed = 1'b1;
            timer_start = item.now_ms;
         end else if (timer_armed && elapsed >= settings.hold_ms) begin
            timer_start = '0;
            timer_armed = 1'b0;
            ctl_mode    = MODE_CODE_FINISHED;
            timer_finishes++;
         end
      end else if (entry == MODE_CODE_FINISHED) begin
         if (item.temp_sample <= settings.reset_temp) ctl_mode = MODE_CODE_STANDBY;
      end

      res.relay_on = (entry == MODE_CODE_WARMING);
      res.mode_now = ctl_mode;
      return res;
   endfunction

   function automatic req_type make_reading(input int temp, input logic press,
                                            input logic level, input logic [TIME_W-1:0] now);
      req_type item;
      item.temp_sample  = temp[TEMP_W-1:0];
      item.button_press = press;
      item.button_level = level;
      item.now_ms       = now;
      return item;
   endfunction

   // Send one item. Valid is left high after acceptance so back-to-back
   // items never lower and raise it in the same step; callers that stop
   // sending drop it through wait_for_results.
   task automatic send_reading(input req_type item);
      int gap;
      gap = feed_idle ? $urandom_range(0, MAX_WAIT) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_temp_sample  <= item.temp_sample;
      req_button_press <= item.button_press;
      req_button_level <= item.button_level;
      req_now_ms       <= item.now_ms;
      do @(posedge clock); while (req_stall);
      predicted_passes.push_back(run_controller_pass(item));
      passes_sent++;
   endtask

   // Drop valid and hold off until every predicted result has arrived.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (predicted_passes.size() != 0);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Put junk above a 10-bit value; the block must use only the low bits.
   function automatic logic [CSR_DATA_W-1:0] pad_temp(input logic [TEMP_W-1:0] v);
      return ($urandom() & ~32'h3FF) | CSR_DATA_W'(v);
   endfunction

   // Write all six registers back to back; only call while the block is idle.
   task automatic apply_settings(input cfg_type c);
      csr_write(CSR_MAX_TEMP,   pad_temp(c.max_temp));
      csr_write(CSR_RESET_TEMP, pad_temp(c.reset_temp));
      csr_write(CSR_HOLD_MS,    c.hold_ms);
      csr_write(CSR_BAND_LOW,   pad_temp(c.band_low));
      csr_write(CSR_BAND_MID,   pad_temp(c.band_mid));
      csr_write(CSR_BAND_HIGH,  pad_temp(c.band_high));
      csr_wr_en <= 1'b0;
      settings = c;
      settings_used++;
   endtask

   task automatic report_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("Mismatch in %s on result %0d: expected %0h, got %0h",
                  field, results_seen, want, got);
      end
   endtask

   // Compare each accepted result with the oldest prediction. All inputs
   // change by nonblocking assignment, so values read here are pre-edge.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (predicted_passes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Result %0d arrived with no item outstanding", results_seen);
            end
         end else begin
            want = predicted_passes.pop_front();
            if (rsp_relay_on !== want.relay_on)
               report_field("relay_on", 32'(want.relay_on), 32'(rsp_relay_on));
            if (rsp_mode_now !== want.mode_now)
               report_field("mode_now", 32'(want.mode_now), 32'(rsp_mode_now));
            if (rsp_led_cmd !== want.led_cmd)
               report_field("led_cmd", 32'(want.led_cmd), 32'(rsp_led_cmd));
            if (rsp_led_colour !== want.led_colour)
               report_field("led_colour", 32'(want.led_colour), 32'(rsp_led_colour));
         end
      end
   end

   // Stall the result side for a drawn number of cycles before each item.
   initial begin : result_pacing
      int hold;
      forever begin
         hold = sink_idle ? $urandom_range(0, MAX_WAIT) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d results outstanding",
                  cycle_count, predicted_passes.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // LED and button handling from reset defaults, plus the temperature extremes.
   task automatic test_button_and_led();
      send_reading(make_reading(0, 1'b0, 1'b0, 32'h0000_0000));     // standby, idle
      send_reading(make_reading(1023, 1'b0, 1'b1, 32'hFFFF_FFFF));  // held, not latched
      send_reading(make_reading(100, 1'b1, 1'b1, 32'd10));          // press into warming
      send_reading(make_reading(100, 1'b1, 1'b1, 32'd20));          // press ignored, latched
      send_reading(make_reading(160, 1'b0, 1'b0, 32'd30));          // release, warming blink
      send_reading(make_reading(120, 1'b1, 1'b0, 32'd40));          // press and release at once
      send_reading(make_reading(250, 1'b1, 1'b0, 32'd50));          // hot press goes to finished
      send_reading(make_reading(400, 1'b0, 1'b0, 32'd60));          // finished stays while hot
      send_reading(make_reading(50, 1'b0, 1'b0, 32'd70));           // cool-down at reset level
      wait_for_results();
   endtask

   // Hold timer: arming, expiry on a button exit, arming kept across a
   // button exit, expiry across the time wrap, and a zero hold.
   task automatic test_hold_timer();
      cfg_type c;
      c = settings;
      c.hold_ms = 32'd100;
      apply_settings(c);
      send_reading(make_reading(100, 1'b1, 1'b0, 32'd1000));        // into warming
      send_reading(make_reading(210, 1'b0, 1'b0, 32'd1010));        // arm
      send_reading(make_reading(220, 1'b0, 1'b0, 32'd1050));        // not yet
      send_reading(make_reading(220, 1'b1, 1'b0, 32'd1110));        // button exit, timer finishes
      send_reading(make_reading(30, 1'b0, 1'b0, 32'd1120));         // back to standby
      send_reading(make_reading(100, 1'b1, 1'b0, 32'd2000));        // into warming
      send_reading(make_reading(200, 1'b0, 1'b0, 32'd2010));        // arm at exactly max
      send_reading(make_reading(100, 1'b1, 1'b0, 32'd2020));        // exit, timer stays armed
      send_reading(make_reading(100, 1'b1, 1'b0, 32'd2200));        // re-enter warming
      send_reading(make_reading(100, 1'b0, 1'b0, 32'd2210));        // stale arm expires
      send_reading(make_reading(10, 1'b0, 1'b0, 32'd2220));         // cool to standby
      send_reading(make_reading(100, 1'b1, 1'b0, 32'hFFFF_FFF0));   // warming near the wrap
      send_reading(make_reading(300, 1'b0, 1'b0, 32'hFFFF_FFF8));   // arm before the wrap
      send_reading(make_reading(300, 1'b0, 1'b0, 32'h0000_0040));   // 72 ms elapsed
      send_reading(make_reading(300, 1'b0, 1'b0, 32'h0000_0060));   // 104 ms, finish
      wait_for_results();
      c.hold_ms = 32'd0;
      apply_settings(c);
      send_reading(make_reading(10, 1'b0, 1'b0, 32'd500));          // finished to standby
      send_reading(make_reading(10, 1'b1, 1'b0, 32'd500));          // into warming
      send_reading(make_reading(700, 1'b0, 1'b0, 32'd500));         // arm
      send_reading(make_reading(700, 1'b0, 1'b0, 32'd500));         // zero hold finishes
      wait_for_results();
   endtask

   // Build one item of a plausible heating session: presses with short
   // holds, a temperature that drifts toward where the mode is headed,
   // and time moving on at a pace tied to the hold. Jumps add noise.
   task automatic random_pass();
      logic press;
      logic level;
      int   step;
      if (btn_hold > 0) begin
         level = 1'b1;
         press = ($urandom_range(0, 9) == 0);
         btn_hold--;
      end else begin
         case ($urandom_range(0, 15))
            0, 1: begin
               press    = 1'b1;
               level    = 1'b1;
               btn_hold = $urandom_range(0, 3);
            end
            2: begin
               press = 1'b1;
               level = 1'b0;
            end
            3: begin
               press = 1'b0;
               level = 1'b1;
            end
            default: begin
               press = 1'b0;
               level = 1'b0;
            end
         endcase
      end

      if ($urandom_range(0, 15) == 0) begin
         walk_temp = $urandom_range(0, 1023);
      end else begin
         step = $urandom_range(0, 48);
         if (ctl_mode == MODE_CODE_WARMING) walk_temp += step;
         else if (ctl_mode == MODE_CODE_FINISHED) walk_temp -= step;
         else walk_temp += $urandom_range(0, 1) ? step : -step;
         if (walk_temp < 0) walk_temp = 0;
         if (walk_temp > 1023) walk_temp = 1023;
      end

      if ($urandom_range(0, 31) == 0) walk_ms = $urandom();
      else walk_ms += $urandom_range(0, settings.hold_ms / 3 + 3);

      send_reading(make_reading(walk_temp, press, level, walk_ms));
   endtask

   // Random sessions under reset values, both register extremes and
   // random settings, with the idling of each side switched in stretches.
   task automatic test_random_heating();
      cfg_type c;
      for (int phase = 0; phase < NUM_SETTINGS; phase++) begin
         case (phase)
            0: begin
               c = '{MAX_TEMP_RST, RESET_TEMP_RST, HOLD_MS_RST,
                     BAND_LOW_RST, BAND_MID_RST, BAND_HIGH_RST};
            end
            1: begin
               c = '0;
            end
            2: begin
               c = '1;
            end
            default: begin
               c.max_temp   = TEMP_W'($urandom_range(0, 1023));
               c.reset_temp = TEMP_W'($urandom_range(0, 1023));
               c.hold_ms    = (phase == 4) ? $urandom() : $urandom_range(0, 400);
               c.band_low   = TEMP_W'($urandom_range(0, 400));
               c.band_mid   = TEMP_W'(c.band_low + $urandom_range(0, 300));
               c.band_high  = (phase == 6) ? TEMP_W'($urandom_range(0, 1023))
                                           : TEMP_W'(c.band_mid + $urandom_range(0, 300));
            end
         endcase
         apply_settings(c);
         walk_temp = $urandom_range(0, 1023);
         // Start one phase just short of the millisecond wrap.
         walk_ms   = (phase == 5) ? 32'hFFFF_FF00 : $urandom();
         btn_hold  = 0;
         for (int n = 0; n < PASSES_PER_SETTING; n++) begin
            if (n % 40 == 0) begin
               feed_idle = ($urandom_range(0, 2) != 0);
               sink_idle = ($urandom_range(0, 2) != 0);
            end
            random_pass();
            // Now and then pause the feed until the pipeline is empty.
            if ($urandom_range(0, 199) == 0) wait_for_results();
         end
         wait_for_results();
      end
      feed_idle = 1'b1;
      sink_idle = 1'b1;
   endtask

   initial begin
      // Predicted state starts from the reset values.
      settings = '{MAX_TEMP_RST, RESET_TEMP_RST, HOLD_MS_RST,
                   BAND_LOW_RST, BAND_MID_RST, BAND_HIGH_RST};
      ctl_mode    = MODE_CODE_STANDBY;
      timer_armed = 1'b0;
      timer_start = '0;
      press_held  = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_button_and_led();
      test_hold_timer();
      test_random_heating();

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (predicted_passes.size() != 0) begin
         $display("%0d results never arrived", predicted_passes.size());
         mismatches += predicted_passes.size();
      end

      $display("Ran %0d controller passes under %0d register settings, %0d results checked,",
               passes_sent, settings_used + 1, results_seen);
      $display("%0d cycles finished by the hold timer, %0d mismatches",
               timer_finishes, mismatches);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hdl
hdl/hcc_pkg.sv
hdl/hcc_pass.sv
hdl/heater_cycle_controller.sv
hdl/hcc_checker.sv
bench/heater_cycle_controller_tb.sv
